FILE: rtl/modfm_oscillator_top_defines.svh
// Assertion macros for the modified-FM oscillator.
// Included by modfm_oscillator_top.sv; SYNTH strips the checks.
`ifndef MODFM_OSCILLATOR_TOP_DEFINES_SVH
`define MODFM_OSCILLATOR_TOP_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication
`define MODFM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("modfm: same-cycle check failed");
// Next-cycle implication
`define MODFM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("modfm: next-cycle check failed");
`else
`define MODFM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define MODFM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/modfm_pkg.sv
// Shared constants, command types and ROM contents for the modified-FM oscillator.
// No dependencies; used by controller, datapath and top level.
`timescale 1ns / 1ps

package modfm_pkg;

	localparam int CTR_BITS   = 48;
	localparam int SIN_BITS   = 10;
	localparam int EXP_BITS   = 10;
	localparam int RATE_BITS  = 18;
	localparam int FREQ_BITS  = 19;
	localparam int D_BITS     = RATE_BITS + 20;
	localparam int FC_BITS    = FREQ_BITS + 16;
	localparam int X1_BITS    = FC_BITS + 8;
	localparam int X2_BITS    = FC_BITS + 16;
	localparam int CNT_BITS   = 6;

	localparam logic [RATE_BITS-1:0] RATE_RESET = RATE_BITS'(48000);
	localparam logic [SIN_BITS-1:0]  QUARTER    = SIN_BITS'(2 ** (SIN_BITS - 2));

	localparam logic [31:0] TWO_PI_Q29     = 32'hC90FDAA2;
	localparam logic [31:0] INV_TWO_PI_Q32 = 32'h28BE60DC;
	localparam logic [31:0] LOG2E_Q30      = 32'h5C551D95;
	localparam logic [31:0] LN2_Q30        = 32'h2C5C85FE;
	localparam longint unsigned ONE_Q30    = 64'd1 << 30;

	// Last bit index of each serial pass
	localparam logic [CNT_BITS-1:0] LAST_CTR  = CNT_BITS'(CTR_BITS - 1);
	localparam logic [CNT_BITS-1:0] LAST_X1   = CNT_BITS'(X1_BITS - 1);
	localparam logic [CNT_BITS-1:0] LAST_X2   = CNT_BITS'(X2_BITS - 1);
	localparam logic [CNT_BITS-1:0] LAST_D    = CNT_BITS'(D_BITS - 1);
	localparam logic [CNT_BITS-1:0] LAST_FRAC = CNT_BITS'(31);

	typedef enum logic [4:0] {
		OP_IDLE, OP_LOAD, OP_MODN, OP_NMSET, OP_MODX1, OP_MODX2, OP_ASET,
		OP_MUL, OP_FRAC, OP_TCSET, OP_M1, OP_M2, OP_M3, OP_M4, OP_M5,
		OP_M6, OP_M7, OP_M8, OP_M9, OP_M10, OP_OUT
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [CNT_BITS-1:0] bit_idx;
	} cmd_t;

	typedef logic signed [31:0] sin_rom_t [2 ** SIN_BITS];
	typedef logic [31:0]        exp_rom_t [2 ** EXP_BITS];

	// Full-wave sine in Q2.30 from a quarter-wave Taylor series
	function automatic sin_rom_t build_sin_rom();
		sin_rom_t rom;
		longint unsigned quarter, q, w, m, x, x2, t;
		int i;
		quarter = 64'd1 << (SIN_BITS - 2);
		for (i = 0; i < 2 ** SIN_BITS; i++) begin
			q  = longint'(i) >> (SIN_BITS - 2);
			w  = longint'(i) & (quarter - 64'd1);
			m  = ((q & 64'd1) != 64'd0) ? quarter - w : w;
			x  = (m * longint'(TWO_PI_Q29)) >> (SIN_BITS - 1);
			x2 = (x * x) >> 30;
			t  = ONE_Q30;
			t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
			t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
			t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
			t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
			t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
			t  = (x * t) >> 30;
			rom[i] = ((q & 64'd2) != 64'd0) ? 32'(64'd0 - t) : 32'(t);
		end
		return rom;
	endfunction

	// 2^frac in Q30 by a degree-12 series of exp(frac*ln2)
	function automatic exp_rom_t build_exp_rom();
		exp_rom_t rom;
		longint unsigned u, t;
		int i;
		for (i = 0; i < 2 ** EXP_BITS; i++) begin
			u = (longint'(i) * longint'(LN2_Q30)) >> EXP_BITS;
			t = ONE_Q30;
			t = ONE_Q30 + ((u * t) >> 30) / 64'd12;
			t = ONE_Q30 + ((u * t) >> 30) / 64'd11;
			t = ONE_Q30 + ((u * t) >> 30) / 64'd10;
			t = ONE_Q30 + ((u * t) >> 30) / 64'd9;
			t = ONE_Q30 + ((u * t) >> 30) / 64'd8;
			t = ONE_Q30 + ((u * t) >> 30) / 64'd7;
			t = ONE_Q30 + ((u * t) >> 30) / 64'd6;
			t = ONE_Q30 + ((u * t) >> 30) / 64'd5;
			t = ONE_Q30 + ((u * t) >> 30) / 64'd4;
			t = ONE_Q30 + ((u * t) >> 30) / 64'd3;
			t = ONE_Q30 + ((u * t) >> 30) / 64'd2;
			t = ONE_Q30 + ((u * t) >> 30);
			rom[i] = 32'(t);
		end
		return rom;
	endfunction

	localparam sin_rom_t SIN_ROM = build_sin_rom();
	localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

FILE: rtl/modfm_ctrl.sv
// Sequencer for the modified-FM oscillator: one-hot state machine issuing
// datapath commands and running the word handshakes. Uses modfm_pkg.
`timescale 1ns / 1ps

module modfm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output modfm_pkg::cmd_t   cmd
);

	typedef enum logic [22:0] {
		ST_IDLE  = 23'h000001,
		ST_MODN  = 23'h000002,
		ST_NMSET = 23'h000004,
		ST_MODA1 = 23'h000008,
		ST_ASET1 = 23'h000010,
		ST_MUL1  = 23'h000020,
		ST_FRAC1 = 23'h000040,
		ST_TCSET = 23'h000080,
		ST_MODA2 = 23'h000100,
		ST_ASET2 = 23'h000200,
		ST_MUL2  = 23'h000400,
		ST_FRAC2 = 23'h000800,
		ST_M1    = 23'h001000,
		ST_M2    = 23'h002000,
		ST_M3    = 23'h004000,
		ST_M4    = 23'h008000,
		ST_M5    = 23'h010000,
		ST_M6    = 23'h020000,
		ST_M7    = 23'h040000,
		ST_M8    = 23'h080000,
		ST_M9    = 23'h100000,
		ST_M10   = 23'h200000,
		ST_DONE  = 23'h400000
	} state_t;

	state_t                        state_q, state_d;
	logic [modfm_pkg::CNT_BITS-1:0] cnt_q, cnt_d;
	logic                          out_valid_q;
	logic                          last_bit;

	assign last_bit  = (cnt_q == '0);
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// Next state, bit counter and command
	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		cmd.op      = modfm_pkg::OP_IDLE;
		cmd.bit_idx = cnt_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = modfm_pkg::OP_LOAD;
					cnt_d   = modfm_pkg::LAST_CTR;
					state_d = ST_MODN;
				end
			end
			ST_MODN: begin
				cmd.op = modfm_pkg::OP_MODN;
				cnt_d  = cnt_q - 1'b1;
				if (last_bit) state_d = ST_NMSET;
			end
			ST_NMSET: begin
				cmd.op  = modfm_pkg::OP_NMSET;
				cnt_d   = modfm_pkg::LAST_X1;
				state_d = ST_MODA1;
			end
			ST_MODA1: begin
				cmd.op = modfm_pkg::OP_MODX1;
				cnt_d  = cnt_q - 1'b1;
				if (last_bit) state_d = ST_ASET1;
			end
			ST_ASET1: begin
				cmd.op  = modfm_pkg::OP_ASET;
				cnt_d   = modfm_pkg::LAST_D;
				state_d = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.op = modfm_pkg::OP_MUL;
				cnt_d  = cnt_q - 1'b1;
				if (last_bit) begin
					cnt_d   = modfm_pkg::LAST_FRAC;
					state_d = ST_FRAC1;
				end
			end
			ST_FRAC1: begin
				cmd.op = modfm_pkg::OP_FRAC;
				cnt_d  = cnt_q - 1'b1;
				if (last_bit) state_d = ST_TCSET;
			end
			ST_TCSET: begin
				cmd.op  = modfm_pkg::OP_TCSET;
				cnt_d   = modfm_pkg::LAST_X2;
				state_d = ST_MODA2;
			end
			ST_MODA2: begin
				cmd.op = modfm_pkg::OP_MODX2;
				cnt_d  = cnt_q - 1'b1;
				if (last_bit) state_d = ST_ASET2;
			end
			ST_ASET2: begin
				cmd.op  = modfm_pkg::OP_ASET;
				cnt_d   = modfm_pkg::LAST_D;
				state_d = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.op = modfm_pkg::OP_MUL;
				cnt_d  = cnt_q - 1'b1;
				if (last_bit) begin
					cnt_d   = modfm_pkg::LAST_FRAC;
					state_d = ST_FRAC2;
				end
			end
			ST_FRAC2: begin
				cmd.op = modfm_pkg::OP_FRAC;
				cnt_d  = cnt_q - 1'b1;
				if (last_bit) state_d = ST_M1;
			end
			ST_M1: begin
				cmd.op  = modfm_pkg::OP_M1;
				state_d = ST_M2;
			end
			ST_M2: begin
				cmd.op  = modfm_pkg::OP_M2;
				state_d = ST_M3;
			end
			ST_M3: begin
				cmd.op  = modfm_pkg::OP_M3;
				state_d = ST_M4;
			end
			ST_M4: begin
				cmd.op  = modfm_pkg::OP_M4;
				state_d = ST_M5;
			end
			ST_M5: begin
				cmd.op  = modfm_pkg::OP_M5;
				state_d = ST_M6;
			end
			ST_M6: begin
				cmd.op  = modfm_pkg::OP_M6;
				state_d = ST_M7;
			end
			ST_M7: begin
				cmd.op  = modfm_pkg::OP_M7;
				state_d = ST_M8;
			end
			ST_M8: begin
				cmd.op  = modfm_pkg::OP_M8;
				state_d = ST_M9;
			end
			ST_M9: begin
				cmd.op  = modfm_pkg::OP_M9;
				state_d = ST_M10;
			end
			ST_M10: begin
				cmd.op  = modfm_pkg::OP_M10;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				// Hand off once the output register is free or being drained
				if (!out_valid_q || !out_stall) begin
					cmd.op  = modfm_pkg::OP_OUT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold state, counter and output flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.op == modfm_pkg::OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/modfm_dp.sv
// Datapath of the modified-FM oscillator: serial modular unit, phase
// arithmetic, sine/exp ROMs and output register. Uses modfm_pkg.
`timescale 1ns / 1ps

module modfm_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  modfm_pkg::cmd_t                   cmd,
	input  logic                              cfg_wr_en,
	input  logic [modfm_pkg::RATE_BITS-1:0]   cfg_wr_data,
	input  logic [modfm_pkg::FREQ_BITS-1:0]   note_frequency,
	input  logic [15:0]                       carrier_ratio,
	input  logic [15:0]                       modulator_ratio,
	input  logic signed [15:0]                r_gain,
	input  logic signed [15:0]                s_gain,
	input  logic [15:0]                       mod_index,
	output logic signed [15:0]                sample_out,
	output logic                              clipped
);

	localparam int DB = modfm_pkg::D_BITS;
	localparam int SB = modfm_pkg::SIN_BITS;
	localparam int EB = modfm_pkg::EXP_BITS;

	// Control state
	logic [modfm_pkg::RATE_BITS-1:0] rate_q;
	logic [modfm_pkg::CTR_BITS-1:0]  ctr_q;

	// Operand and serial registers
	logic [DB-1:0]                   d_q, r_q, a_q, nm_q;
	logic [31:0]                     q_q, tc_q;
	logic [modfm_pkg::FC_BITS-1:0]   fc_q;
	logic [modfm_pkg::X2_BITS-1:0]   fcm_q;
	logic [15:0]                     mr_q, k_q;
	logic signed [15:0]              rg_q, sg_q;

	// Math registers
	logic signed [31:0]              rom_q, sin_q, cos_q, cv_q;
	logic [31:0]                     exp_q;
	logic signed [32:0]              sk_q;
	logic signed [64:0]              ska_q;
	logic signed [47:0]              rc_q;
	logic signed [34:0]              ph_q;
	logic signed [42:0]              x_q;
	logic [31:0]                     turn_q, total_q;
	logic signed [45:0]              y_q;
	logic signed [15:0]              ip_q;
	logic signed [64:0]              prod_q, v_q;
	logic signed [16:0]              sh_q;

	// Serial step signals
	logic [modfm_pkg::X1_BITS-1:0]   x1;
	logic                            bit_in;
	logic [DB:0]                     dbl, dbl_red, sum, sum_red, d_ext;
	logic                            dbl_ge;
	logic [modfm_pkg::RATE_BITS-1:0] rate_eff;

	// Math combinational signals
	logic [SB-1:0]                   sidx, sin_addr;
	logic signed [35:0]              t1;
	logic signed [52:0]              xk;
	logic signed [67:0]              turn_full;
	logic signed [65:0]              y_full;
	logic signed [16:0]              neg_sh;
	logic [5:0]                      sh_amt;
	logic signed [64:0]              v_d;

	assign x1       = {fc_q, 8'd0};
	assign d_ext    = {1'b0, d_q};
	assign rate_eff = (rate_q == '0) ? modfm_pkg::RATE_BITS'(1) : rate_q;

	// Pick the bit shifted into the remainder
	always_comb begin
		case (cmd.op)
			modfm_pkg::OP_MODN:  bit_in = ctr_q[cmd.bit_idx];
			modfm_pkg::OP_MODX1: bit_in = x1[cmd.bit_idx];
			modfm_pkg::OP_MODX2: bit_in = fcm_q[cmd.bit_idx];
			default:             bit_in = 1'b0;
		endcase
	end

	// Double, optionally add, reduce modulo d
	assign dbl     = {r_q, bit_in};
	assign dbl_ge  = (dbl >= d_ext);
	assign dbl_red = dbl_ge ? dbl - d_ext : dbl;
	assign sum     = dbl_red + {1'b0, a_q};
	assign sum_red = (sum >= d_ext) ? sum - d_ext : sum;

	// Sine ROM address
	assign sidx = q_q[31 -: SB];
	always_comb begin
		case (cmd.op)
			modfm_pkg::OP_M1: sin_addr = sidx;
			modfm_pkg::OP_M2: sin_addr = sidx + modfm_pkg::QUARTER;
			default:          sin_addr = total_q[31 -: SB] + modfm_pkg::QUARTER;
		endcase
	end

	// Exponent argument and phase offset products
	assign t1        = $signed(rc_q[47:12]) - 36'sd1073741824;
	assign xk        = t1 * $signed({1'b0, k_q});
	assign turn_full = ph_q * $signed({1'b0, modfm_pkg::INV_TWO_PI_Q32});
	assign y_full    = $signed(x_q[42:10]) * $signed({1'b0, modfm_pkg::LOG2E_Q30});

	// Scale the product by 2^ip with round-half-up
	assign neg_sh = 17'sd0 - sh_q;
	assign sh_amt = sh_q[5:0];
	always_comb begin
		if (prod_q == '0 || sh_q >= 17'sd63) begin
			v_d = '0;
		end else if (sh_q >= 17'sd1) begin
			v_d = (prod_q + (65'sd1 <<< (sh_amt - 6'd1))) >>> sh_amt;
		end else if (neg_sh >= 17'sd16 || prod_q > 65'sd32767 || prod_q < -65'sd32768) begin
			v_d = (prod_q > 65'sd0) ? 65'sd40000 : -65'sd40000;
		end else begin
			v_d = prod_q <<< neg_sh[3:0];
		end
	end

	// Hold configuration and the sample counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= modfm_pkg::RATE_RESET;
			ctr_q  <= '0;
		end else begin
			if (cfg_wr_en) rate_q <= cfg_wr_data;
			if (cmd.op == modfm_pkg::OP_NMSET) ctr_q <= ctr_q + 1'b1;
		end
	end

	// ROM reads
	always_ff @(posedge clk) begin
		rom_q <= modfm_pkg::SIN_ROM[sin_addr];
		exp_q <= modfm_pkg::EXP_ROM[y_q[29 -: EB]];
	end

	// Advance the datapath by command
	always_ff @(posedge clk) begin
		case (cmd.op)
			modfm_pkg::OP_LOAD: begin
				d_q  <= {rate_eff, 20'd0};
				fc_q <= note_frequency * carrier_ratio;
				mr_q <= modulator_ratio;
				k_q  <= mod_index;
				rg_q <= r_gain;
				sg_q <= s_gain;
				r_q  <= '0;
			end
			modfm_pkg::OP_MODN, modfm_pkg::OP_MODX1, modfm_pkg::OP_MODX2: begin
				r_q <= dbl_red[DB-1:0];
			end
			modfm_pkg::OP_NMSET: begin
				nm_q  <= r_q;
				r_q   <= '0;
				fcm_q <= fc_q * mr_q;
			end
			modfm_pkg::OP_ASET: begin
				a_q <= r_q;
				r_q <= '0;
			end
			modfm_pkg::OP_MUL: begin
				r_q <= nm_q[cmd.bit_idx] ? sum_red[DB-1:0] : dbl_red[DB-1:0];
			end
			modfm_pkg::OP_FRAC: begin
				r_q <= dbl_red[DB-1:0];
				q_q <= {q_q[30:0], dbl_ge};
			end
			modfm_pkg::OP_TCSET: begin
				tc_q <= q_q;
				r_q  <= '0;
			end
			modfm_pkg::OP_M1: begin
				sk_q <= sg_q * $signed({1'b0, k_q});
			end
			modfm_pkg::OP_M2: begin
				sin_q <= rom_q;
			end
			modfm_pkg::OP_M3: begin
				cos_q <= rom_q;
				ska_q <= sk_q * sin_q;
			end
			modfm_pkg::OP_M4: begin
				rc_q <= rg_q * cos_q;
				ph_q <= ska_q[64:30];
			end
			modfm_pkg::OP_M5: begin
				x_q    <= xk[52:10];
				turn_q <= turn_full[53:22];
			end
			modfm_pkg::OP_M6: begin
				y_q     <= y_full[65:20];
				total_q <= tc_q + turn_q;
			end
			modfm_pkg::OP_M7: begin
				ip_q <= y_q[45:30];
			end
			modfm_pkg::OP_M8: begin
				cv_q <= rom_q;
			end
			modfm_pkg::OP_M9: begin
				prod_q <= $signed({1'b0, exp_q}) * cv_q;
				sh_q   <= 17'sd45 - 17'(ip_q);
			end
			modfm_pkg::OP_M10: begin
				v_q <= v_d;
			end
			modfm_pkg::OP_OUT: begin
				// Saturate to Q1.15
				if (v_q > 65'sd32767) begin
					sample_out <= 16'sh7FFF;
					clipped    <= 1'b1;
				end else if (v_q < -65'sd32768) begin
					sample_out <= 16'sh8000;
					clipped    <= 1'b1;
				end else begin
					sample_out <= v_q[15:0];
					clipped    <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: rtl/modfm_oscillator_top.sv
// Top level of the modified-FM oscillator: controller plus datapath.
// Depends on modfm_pkg, modfm_ctrl, modfm_dp and the assertion macro header.
//
//   channel  direction  handshake            word
//   in       input      in_valid / in_stall  note_frequency .. mod_index
//   out      output     out_valid/out_stall  sample_out, clipped
//   cfg      input      cfg_wr_en            cfg_wr_data (sample_rate_hz)
//
// Each word runs the bit-serial modulo, modular multiply and fraction
// passes over the 38-bit time base (48+43+38+32+51+38+32 steps), then a
// ten-step arithmetic tail, with bookkeeping states between the passes.
// Reset idles the state machine, clears the sample counter and sets the rate register to 48000.
// A new word is taken while a finished result still waits under out_stall.
`timescale 1ns / 1ps
`include "modfm_oscillator_top_defines.svh"

module modfm_oscillator_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [modfm_pkg::RATE_BITS-1:0]   cfg_wr_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [modfm_pkg::FREQ_BITS-1:0]   note_frequency,
	input  logic [15:0]                       carrier_ratio,
	input  logic [15:0]                       modulator_ratio,
	input  logic signed [15:0]                r_gain,
	input  logic signed [15:0]                s_gain,
	input  logic [15:0]                       mod_index,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [15:0]                sample_out,
	output logic                              clipped
);

	modfm_pkg::cmd_t cmd;

	modfm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	modfm_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.note_frequency  (note_frequency),
		.carrier_ratio   (carrier_ratio),
		.modulator_ratio (modulator_ratio),
		.r_gain          (r_gain),
		.s_gain          (s_gain),
		.mod_index       (mod_index),
		.sample_out      (sample_out),
		.clipped         (clipped)
	);

	// A taken word keeps the input closed while it is worked on
	`MODFM_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	// A clipped sample sits at a rail
	`MODFM_ASSERT_IMPL(a_clip_at_rail, clk, arst_n, out_valid && clipped, sample_out == 16'sh7FFF || sample_out == 16'sh8000)

endmodule

FILE: sim/modfm_check.sv
// Checker for the modified-FM oscillator: watches the word channels and the rate register.
// It predicts each sample, compares it with the block's output and counts mismatches.
// Depends on modfm_pkg for the field widths and the reset rate.
`timescale 1ns / 1ps

module modfm_check (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [modfm_pkg::RATE_BITS-1:0] cfg_wr_data,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic [modfm_pkg::FREQ_BITS-1:0] note_frequency,
	input  logic [15:0]                     carrier_ratio,
	input  logic [15:0]                     modulator_ratio,
	input  logic signed [15:0]              r_gain,
	input  logic signed [15:0]              s_gain,
	input  logic [15:0]                     mod_index,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic signed [15:0]              sample_out,
	input  logic                            clipped,
	output int                              errors,
	output int                              pending
);

	localparam longint unsigned TURN_2PI  = 64'hC90FDAA2;
	localparam longint          INV_2PI   = 64'h28BE60DC;
	localparam longint          LOG2E     = 64'h5C551D95;
	localparam longint unsigned LN2       = 64'h2C5C85FE;
	localparam longint          ONE       = 64'd1 << 30;
	localparam int              TAB_BITS  = 10;
	localparam int              QTR       = 1 << (TAB_BITS - 2);
	localparam int              CTR_WIDTH = 48;

	typedef struct {
		logic signed [15:0] smp;
		logic               clp;
	} sample_t;

	sample_t                         sample_q[$];
	logic [modfm_pkg::RATE_BITS-1:0] rate;
	logic [CTR_WIDTH-1:0]            n_count;

	// a*b mod m, shift and add
	function automatic longint unsigned mod_mul(longint unsigned a, longint unsigned b,
			longint unsigned m);
		longint unsigned r;
		r = 0;
		for (int i = 63; i >= 0; i--) begin
			r = r << 1;
			if (r >= m) r -= m;
			if (b[i]) begin
				r += a;
				if (r >= m) r -= m;
			end
		end
		return r;
	endfunction

	// residue r/m as a 32-bit turn fraction
	function automatic logic [31:0] turn_frac(longint unsigned r, longint unsigned m);
		logic [31:0] q;
		q = 0;
		for (int i = 0; i < 32; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= m) begin
				r -= m;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	// sine in Q2.30 at a table index, quarter-wave polynomial
	function automatic longint sine_at(int idx);
		longint unsigned dv[5];
		longint unsigned x, x2, t;
		int q, w, m;
		dv = '{110, 72, 42, 20, 6};
		idx = idx & ((1 << TAB_BITS) - 1);
		q = idx >> (TAB_BITS - 2);
		w = idx & (QTR - 1);
		m = (q & 1) ? QTR - w : w;
		x = (longint'(m) * TURN_2PI) >> (TAB_BITS - 1);
		x2 = (x * x) >> 30;
		t = ONE;
		for (int i = 0; i < 5; i++)
			t = ONE - ((x2 * t) >> 30) / dv[i];
		t = (x * t) >> 30;
		return (q & 2) ? -longint'(t) : longint'(t);
	endfunction

	// 2^(fidx/1024) in Q30
	function automatic longint pow2_frac(longint unsigned fidx);
		longint unsigned u, t;
		u = (fidx * LN2) >> TAB_BITS;
		t = ONE;
		for (int k = 12; k >= 1; k--)
			t = ONE + ((u * t) >> 30) / longint'(k);
		return longint'(t);
	endfunction

	// one output sample from the current counter and rate
	function automatic sample_t osc_sample();
		sample_t         o;
		longint unsigned f, c, mr, rt, d, nm;
		longint          r, s, k, sin_m, cos_m, x, y, ip, fr, ex, a, turn, cv, prod, v, sh;
		logic [31:0]     tc, tm, total;
		f  = 64'(note_frequency);
		c  = 64'(carrier_ratio);
		mr = 64'(modulator_ratio);
		r  = longint'(r_gain);
		s  = longint'(s_gain);
		k  = longint'(mod_index);
		rt = (rate == '0) ? 64'd1 : 64'(rate);
		d  = rt << 20;
		nm = 64'(n_count) % d;
		tc = turn_frac(mod_mul(((f * c) << 8) % d, nm, d), d);
		tm = turn_frac(mod_mul((f * c * mr) % d, nm, d), d);
		sin_m = sine_at(tm >> (32 - TAB_BITS));
		cos_m = sine_at((tm >> (32 - TAB_BITS)) + QTR);
		x  = (k * (((r * cos_m) >>> 12) - ONE)) >>> 10;
		y  = ((x >>> 10) * LOG2E) >>> 20;
		ip = y >>> 30;
		fr = y - ip * ONE;
		ex = pow2_frac(longint'(fr) >> (30 - TAB_BITS));
		a  = (s * k * sin_m) >>> 30;
		turn  = (a * INV_2PI) >>> 22;
		total = tc + turn[31:0];
		cv = sine_at((total >> (32 - TAB_BITS)) + QTR);
		prod = ex * cv;
		sh = 45 - ip;
		o.clp = 1'b0;
		if (prod == 0 || sh >= 63)
			v = 0;
		else if (sh >= 1)
			v = (prod + (longint'(1) << (sh - 1))) >>> sh;
		else if (-sh >= 16 || prod > 32767 || prod < -32768)
			v = (prod > 0) ? 40000 : -40000;
		else
			v = prod <<< (-sh);
		if (v > 32767) begin
			v = 32767;
			o.clp = 1'b1;
		end
		if (v < -32768) begin
			v = -32768;
			o.clp = 1'b1;
		end
		o.smp = v[15:0];
		return o;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	assign pending = sample_q.size();

	// track the register, predict accepted words, compare delivered ones
	always @(posedge clk or negedge arst_n) begin
		sample_t w;
		if (!arst_n) begin
			rate    <= modfm_pkg::RATE_RESET;
			n_count <= '0;
			errors  <= 0;
			sample_q.delete();
		end else begin
			if (cfg_wr_en)
				rate <= cfg_wr_data;
			if (in_valid && !in_stall) begin
				sample_q.push_back(osc_sample());
				n_count <= n_count + 1'b1;
			end
			if (out_valid && !out_stall) begin
				if (sample_q.size() == 0) begin
					report("unexpected word sample_out", longint'(sample_out), 64'sd0);
				end else begin
					w = sample_q.pop_front();
					if (sample_out !== w.smp)
						report("sample_out", longint'(sample_out), longint'(w.smp));
					if (clipped !== w.clp)
						report("clipped", longint'(clipped), longint'(w.clp));
				end
			end
		end
	end

endmodule

FILE: sim/tb_top.sv
// Testbench top for the modified-FM oscillator: clock, reset, stimulus and verdict.
// Depends on modfm_pkg, modfm_oscillator_top and the modfm_check checker.
`timescale 1ns / 1ps

module tb_top;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_wr_en;
	logic [modfm_pkg::RATE_BITS-1:0] cfg_wr_data;
	logic                            in_valid;
	logic                            in_stall;
	logic [modfm_pkg::FREQ_BITS-1:0] note_frequency;
	logic [15:0]                     carrier_ratio;
	logic [15:0]                     modulator_ratio;
	logic signed [15:0]              r_gain;
	logic signed [15:0]              s_gain;
	logic [15:0]                     mod_index;
	logic                            out_valid;
	logic                            out_stall;
	logic signed [15:0]              sample_out;
	logic                            clipped;
	logic                            quiet;
	int                              errors;
	int                              pending;

	modfm_oscillator_top DUT (.*);
	modfm_check u_check (.*);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// random output stall, none during a quiet stretch
	always @(negedge clk) begin
		out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 11);
	end

	// present one word and hold it until accepted, then maybe idle
	task automatic send_word(int f, int c, int m, int r, int s, int k);
		note_frequency  = modfm_pkg::FREQ_BITS'(f);
		carrier_ratio   = 16'(c);
		modulator_ratio = 16'(m);
		r_gain          = 16'(r);
		s_gain          = 16'(s);
		mod_index       = 16'(k);
		in_valid        = 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		while (!quiet && $urandom_range(0, 99) < 11) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
	endtask

	// drain outstanding words, then write the rate
	task automatic set_rate(int value);
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		cfg_wr_data = modfm_pkg::RATE_BITS'(value);
		cfg_wr_en   = 1'b1;
		@(negedge clk);
		cfg_wr_en   = 1'b0;
	endtask

	task automatic random_words(int count);
		int k;
		for (int i = 0; i < count; i++) begin
			quiet = (i >= count / 2 && i < count / 2 + 60);
			k = ($urandom_range(0, 1)) ? $urandom_range(0, 4096) : $urandom_range(0, 65535);
			send_word($urandom_range(0, 524287), $urandom_range(0, 65535),
				$urandom_range(0, 65535), $urandom_range(0, 65535),
				$urandom_range(0, 65535), k);
		end
		quiet = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		quiet = 1'b0;
		note_frequency = '0;
		carrier_ratio = '0;
		modulator_ratio = '0;
		r_gain = '0;
		s_gain = '0;
		mod_index = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// field extremes, huge and tiny exponents at the reset rate
		send_word(0, 0, 0, 0, 0, 0);
		send_word(524287, 65535, 65535, 32767, 32767, 65535);
		send_word(400000, 256, 256, 4096, 4096, 1024);
		send_word(7040, 256, 512, 32767, 0, 65535);
		send_word(7040, 256, 512, -32768, 0, 65535);
		send_word(7040, 256, 256, -32768, -32768, 65535);
		send_word(1, 1, 1, -1, -1, 1);
		send_word(440 * 16, 65535, 0, 4096, -32768, 65535);
		send_word(440 * 16, 384, 300, 0, 32767, 2048);
		send_word(524287, 0, 65535, 32767, 32767, 0);
		random_words(280);

		// sweep the rate: extremes, zero, above range, typical
		set_rate(8000);
		send_word(8000 * 16, 256, 256, 4096, 4096, 1024);
		random_words(280);
		set_rate(192000);
		random_words(280);
		set_rate(0);
		send_word(16, 256, 256, 4096, 4096, 1024);
		random_words(280);
		set_rate(262143);
		random_words(280);
		set_rate(44100);
		random_words(280);

		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (400) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// give up after a generous time
	initial begin
		#20000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: modfm_oscillator_top.f
+incdir+rtl
rtl/modfm_pkg.sv
rtl/modfm_ctrl.sv
rtl/modfm_dp.sv
rtl/modfm_oscillator_top.sv
sim/modfm_check.sv
sim/tb_top.sv
